@@ rtl/core/obd_pkg.sv @@
// Shared types and constants for the onset autocorrelation beat detector.
// No dependencies; every other file in rtl/core uses this package.
package obd_pkg;

    localparam int WINDOW_LEN_DEF = 64;
    localparam int LAG_LOW_DEF    = 4;
    localparam int LAG_HIGH_DEF   = 16;

    localparam int DIV_W   = 32;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [15:0] SCORE_MAX    = 16'd100;
    localparam logic [6:0]  SCORE_MAX_7  = 7'd100;
    localparam logic [31:0] MS_PER_MIN   = 32'd60000;
    localparam logic [15:0] PEAK_SAT     = 16'hFFFF;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_FRAME_LENGTH   = 3'd0;
    localparam logic [2:0] REG_ONSET_FLOOR    = 3'd1;
    localparam logic [2:0] REG_BEAT_ON_LEVEL  = 3'd2;
    localparam logic [2:0] REG_BEAT_OFF_LEVEL = 3'd3;
    localparam logic [2:0] REG_SUSTAIN_TIME   = 3'd4;
    localparam logic [2:0] REG_QUIET_TIME     = 3'd5;

    typedef struct packed {
        logic [7:0]  sample_level;
        logic [31:0] time_ms;
    } t_in_beat;

    typedef struct packed {
        logic       is_listening;
        logic [6:0] beat_score;
        logic [7:0] tempo_bpm;
        logic       frame_closed;
    } t_out_beat;

    typedef struct packed {
        logic [9:0]  frame_length;
        logic [13:0] onset_floor;
        logic [15:0] beat_on_level;
        logic [15:0] beat_off_level;
        logic [15:0] sustain_time;
        logic [15:0] quiet_time;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_N_GO,
        S_N_WAIT,
        S_NSET,
        S_SHIFT,
        S_ONSET,
        S_CORR,
        S_PK_GO,
        S_PK_WAIT,
        S_TP_GO,
        S_TP_WAIT,
        S_FLIP,
        S_OUT
    } t_state;

endpackage

@@ rtl/core/obd_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on obd_pkg for the request struct and the word width.
module obd_divider (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  obd_pkg::t_div_req        i_req,
    output logic                     o_done,
    output logic [obd_pkg::DIV_W-1:0] o_quot
);

    localparam int CW = $clog2(obd_pkg::DIV_W);

    logic                      r_busy;
    logic                      r_done;
    logic [CW-1:0]             r_cnt;
    logic [obd_pkg::DIV_W-1:0] r_rem;
    logic [obd_pkg::DIV_W-1:0] r_quo;
    logic [obd_pkg::DIV_W-1:0] r_dvs;
    logic [obd_pkg::DIV_W:0]   sh;
    logic                      fits;

    always_comb begin
        sh   = {r_rem, r_quo[obd_pkg::DIV_W-1]};
        fits = (sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(obd_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? obd_pkg::DIV_W'(sh - {1'b0, r_dvs}) : sh[obd_pkg::DIV_W-1:0];
            r_quo <= {r_quo[obd_pkg::DIV_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

@@ rtl/core/obd_cfg_regs.sv @@
// APB-style configuration registers of the beat detector.
// Depends on obd_pkg for the register indexes and the configuration struct.
module obd_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [obd_pkg::PADDR_W-1:0]  paddr,
    input  logic [obd_pkg::PDATA_W-1:0]  pwdata,
    output logic [obd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output obd_pkg::t_cfg                o_cfg
);

    obd_pkg::t_cfg r_cfg;
    logic [2:0]    idx;
    logic          wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_length   <= 10'd50;
            r_cfg.onset_floor    <= 14'd64;
            r_cfg.beat_on_level  <= 16'd40;
            r_cfg.beat_off_level <= 16'd25;
            r_cfg.sustain_time   <= 16'd3000;
            r_cfg.quiet_time     <= 16'd5000;
        end else if (wr) begin
            case (idx)
                obd_pkg::REG_FRAME_LENGTH:   r_cfg.frame_length   <= pwdata[9:0];
                obd_pkg::REG_ONSET_FLOOR:    r_cfg.onset_floor    <= pwdata[13:0];
                obd_pkg::REG_BEAT_ON_LEVEL:  r_cfg.beat_on_level  <= pwdata[15:0];
                obd_pkg::REG_BEAT_OFF_LEVEL: r_cfg.beat_off_level <= pwdata[15:0];
                obd_pkg::REG_SUSTAIN_TIME:   r_cfg.sustain_time   <= pwdata[15:0];
                obd_pkg::REG_QUIET_TIME:     r_cfg.quiet_time     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            obd_pkg::REG_FRAME_LENGTH:   prdata = 32'(r_cfg.frame_length);
            obd_pkg::REG_ONSET_FLOOR:    prdata = 32'(r_cfg.onset_floor);
            obd_pkg::REG_BEAT_ON_LEVEL:  prdata = 32'(r_cfg.beat_on_level);
            obd_pkg::REG_BEAT_OFF_LEVEL: prdata = 32'(r_cfg.beat_off_level);
            obd_pkg::REG_SUSTAIN_TIME:   prdata = 32'(r_cfg.sustain_time);
            obd_pkg::REG_QUIET_TIME:     prdata = 32'(r_cfg.quiet_time);
            default:                     prdata = '0;
        endcase
    end

endmodule

@@ rtl/core/onset_autocorrelation_beat_detector.sv @@
// Onset autocorrelation beat detector. Each input beat is a level sample with a millisecond
// timestamp and yields exactly one output beat. A sample that closes no frame is dominated
// by one pass of the shared divider that counts elapsed frames. A sample that closes frames
// also pushes each closed frame into the window (at most WINDOW_LEN of them). Once the
// window is full, every closing sample also runs an onset pass over the window, an
// autocorrelation over lags LAG_LOW to LAG_HIGH through one multiply-accumulate unit, and
// up to two more divider passes for peakiness and tempo. The input stall stays high for the
// whole of that work. A finished result sits in an output register, so the next sample is
// accepted while it waits to be taken.
// Depends on obd_pkg, obd_cfg_regs and obd_divider.
module onset_autocorrelation_beat_detector #(
    parameter int WINDOW_LEN = obd_pkg::WINDOW_LEN_DEF,
    parameter int LAG_LOW    = obd_pkg::LAG_LOW_DEF,
    parameter int LAG_HIGH   = obd_pkg::LAG_HIGH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  obd_pkg::t_in_beat           i_in_data,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output obd_pkg::t_out_beat          o_out_data,
    input  logic                        i_out_stall,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [obd_pkg::PADDR_W-1:0] paddr,
    input  logic [obd_pkg::PDATA_W-1:0] pwdata,
    output logic [obd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int AW     = $clog2(WINDOW_LEN);
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int ACC_W  = AW + 16;
    localparam int SUM_W  = AW + 8;
    localparam int LAG_W  = $clog2(LAG_HIGH + 1);

    obd_pkg::t_cfg     cfg;
    obd_pkg::t_div_req div_req;
    logic              div_done;
    logic [31:0]       div_quot;
    logic [9:0]        eff_fl;

    obd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    obd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // A frame length of zero behaves as one millisecond.
    assign eff_fl = (cfg.frame_length == '0) ? 10'd1 : cfg.frame_length;

    // Envelope window kept as a ring: r_wp points at the oldest entry.
    logic [7:0] env_mem   [WINDOW_LEN];
    logic [7:0] onset_mem [WINDOW_LEN];

    obd_pkg::t_state r_state, n_state;

    logic [7:0]        r_level;
    logic [31:0]       r_now;
    logic              r_frame_open;
    logic [31:0]       r_frame_start;
    logic [7:0]        r_frame_peak;
    logic [31:0]       r_n;
    logic [FILL_W-1:0] r_m;
    logic [FILL_W-1:0] r_k;
    logic [FILL_W-1:0] r_fill;
    logic [AW-1:0]     r_wp;
    logic              r_closed;

    // Onset pass.
    logic [AW:0]       r_ci;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_idx;
    logic [7:0]        r_env_q;
    logic [7:0]        r_prev;
    logic [SUM_W-1:0]  r_onset_sum;
    logic [ACC_W-1:0]  r_e0;

    // Correlation pass.
    logic              r_issue;
    logic [LAG_W-1:0]  r_lag;
    logic [AW-1:0]     r_ii;
    logic              r_cv;
    logic              r_cl;
    logic              r_cdone;
    logic [LAG_W-1:0]  r_clag;
    logic [7:0]        r_on_a;
    logic [7:0]        r_on_b;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  r_best;
    logic [LAG_W-1:0]  r_top_lag;

    logic [15:0]       r_peak;
    logic [7:0]        r_tempo;
    logic [31:0]       r_flip_start;
    logic              r_flip_timing;
    logic              r_listening;

    logic               r_out_valid;
    obd_pkg::t_out_beat r_out;

    // Decoded control from the sequencer.
    logic        accept;
    logic        out_load;
    logic        shift_last;
    logic        onset_last;
    logic        last_i;

    logic [AW:0]    ring_sum;
    logic [AW-1:0]  ring_addr;
    logic [7:0]     onset_val;
    logic [15:0]    onset_sq;
    logic [15:0]    prod;
    logic [ACC_W-1:0] corr_sum;
    logic [7:0]     shift_val;
    logic [31:0]    flip_base;
    logic           active;
    logic           flip_req;

    assign o_in_stall  = (r_state != obd_pkg::S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            obd_pkg::S_IDLE:    if (accept) n_state = obd_pkg::S_N_GO;
            obd_pkg::S_N_GO:    n_state = obd_pkg::S_N_WAIT;
            obd_pkg::S_N_WAIT: begin
                if (div_done) n_state = (div_quot == '0) ? obd_pkg::S_OUT : obd_pkg::S_NSET;
            end
            obd_pkg::S_NSET:    n_state = obd_pkg::S_SHIFT;
            obd_pkg::S_SHIFT: begin
                if (shift_last) begin
                    n_state = (r_fill == FILL_W'(WINDOW_LEN)) ? obd_pkg::S_ONSET
                                                              : obd_pkg::S_FLIP;
                end
            end
            obd_pkg::S_ONSET:   if (onset_last) n_state = obd_pkg::S_CORR;
            obd_pkg::S_CORR:    if (r_cv && r_cdone) n_state = obd_pkg::S_PK_GO;
            obd_pkg::S_PK_GO: begin
                n_state = (r_e0 == '0) ? obd_pkg::S_TP_GO : obd_pkg::S_PK_WAIT;
            end
            obd_pkg::S_PK_WAIT: if (div_done) n_state = obd_pkg::S_TP_GO;
            obd_pkg::S_TP_GO: begin
                n_state = (r_top_lag == '0) ? obd_pkg::S_FLIP : obd_pkg::S_TP_WAIT;
            end
            obd_pkg::S_TP_WAIT: if (div_done) n_state = obd_pkg::S_FLIP;
            obd_pkg::S_FLIP:    n_state = obd_pkg::S_OUT;
            obd_pkg::S_OUT:     if (out_load) n_state = obd_pkg::S_IDLE;
            default:            n_state = obd_pkg::S_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb begin
        div_req  = '0;
        out_load = 1'b0;
        case (r_state)
            obd_pkg::S_N_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_now - r_frame_start;
                div_req.divisor  = 32'(eff_fl);
            end
            obd_pkg::S_PK_GO: begin
                div_req.start    = (r_e0 != '0);
                div_req.dividend = 32'(r_best) * 32'(obd_pkg::SCORE_MAX);
                div_req.divisor  = 32'(r_e0);
            end
            obd_pkg::S_TP_GO: begin
                div_req.start    = (r_top_lag != '0);
                div_req.dividend = obd_pkg::MS_PER_MIN;
                div_req.divisor  = 32'(r_top_lag) * 32'(eff_fl);
            end
            obd_pkg::S_OUT: out_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    // ---------------- datapath helpers ----------------
    always_comb begin
        shift_last = (r_k == r_m - 1'b1);
        onset_last = r_rd_vld && (r_rd_idx == AW'(WINDOW_LEN - 1));
        last_i     = (r_ii == AW'(WINDOW_LEN - 1));

        // Logical window index to ring address.
        ring_sum  = {1'b0, r_wp} + {1'b0, r_ci[AW-1:0]};
        ring_addr = (ring_sum >= (AW+1)'(WINDOW_LEN))
                  ? AW'(ring_sum - (AW+1)'(WINDOW_LEN)) : ring_sum[AW-1:0];

        // Positive rise between neighbors; the first entry has none.
        onset_val = (r_rd_idx != '0 && r_env_q > r_prev) ? (r_env_q - r_prev) : 8'd0;
        onset_sq  = onset_val * onset_val;

        prod     = r_on_a * r_on_b;
        corr_sum = r_acc + ACC_W'(prod);

        // The first frame pushed carries the held peak unless the gap
        // overflows the window; the rest carry the current level.
        shift_val = (r_k == '0 && r_n <= 32'(WINDOW_LEN)) ? r_frame_peak : r_level;

        // Beat test with hysteresis on the peakiness threshold.
        active = (r_fill == FILL_W'(WINDOW_LEN))
              && (32'(r_onset_sum) >= 32'(cfg.onset_floor))
              && (r_peak >= (r_listening ? cfg.beat_off_level : cfg.beat_on_level));
        flip_req  = r_listening ? !active : active;
        flip_base = r_flip_timing ? r_flip_start : r_now;
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (r_state == obd_pkg::S_SHIFT) begin
            env_mem[r_wp] <= shift_val;
        end
        r_env_q <= env_mem[ring_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == obd_pkg::S_ONSET && r_rd_vld) begin
            onset_mem[r_rd_idx] <= onset_val;
        end
        r_on_a <= onset_mem[r_ii];
        r_on_b <= onset_mem[r_ii - AW'(r_lag)];
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= obd_pkg::S_IDLE;
            r_frame_open  <= 1'b0;
            r_frame_start <= '0;
            r_frame_peak  <= '0;
            r_fill        <= '0;
            r_wp          <= '0;
            r_peak        <= '0;
            r_tempo       <= '0;
            r_flip_start  <= '0;
            r_flip_timing <= 1'b0;
            r_listening   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_issue       <= 1'b0;
            r_cv          <= 1'b0;
        end else begin
            r_state <= n_state;

            // A new result may replace one that is being taken in the same cycle.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (accept) begin
                if (!r_frame_open) begin
                    r_frame_open  <= 1'b1;
                    r_frame_start <= i_in_data.time_ms;
                    r_frame_peak  <= i_in_data.sample_level;
                end else if (i_in_data.sample_level > r_frame_peak) begin
                    r_frame_peak  <= i_in_data.sample_level;
                end
            end

            if (r_state == obd_pkg::S_NSET) begin
                r_fill <= (r_n >= 32'(WINDOW_LEN) - 32'(r_fill))
                        ? FILL_W'(WINDOW_LEN) : r_fill + FILL_W'(r_n);
                r_frame_start <= r_frame_start + r_n * 32'(eff_fl);
            end

            if (r_state == obd_pkg::S_SHIFT) begin
                r_wp <= (r_wp == AW'(WINDOW_LEN - 1)) ? '0 : r_wp + 1'b1;
                if (shift_last) r_frame_peak <= r_level;
            end

            // Onset pass: issue one read per cycle and process the one before.
            r_rd_vld <= (r_state == obd_pkg::S_ONSET) && (r_ci < (AW+1)'(WINDOW_LEN));

            // Correlation pass: one product per cycle, lags back to back.
            r_cv <= (r_state == obd_pkg::S_CORR) && r_issue;
            if (r_state == obd_pkg::S_ONSET && onset_last) begin
                r_issue <= 1'b1;
            end else if (r_state == obd_pkg::S_CORR && r_issue && last_i
                         && r_lag == LAG_W'(LAG_HIGH)) begin
                r_issue <= 1'b0;
            end

            if (r_state == obd_pkg::S_PK_WAIT && div_done) begin
                r_peak <= (div_quot > 32'(obd_pkg::PEAK_SAT)) ? obd_pkg::PEAK_SAT
                                                              : div_quot[15:0];
            end else if (r_state == obd_pkg::S_PK_GO && r_e0 == '0) begin
                r_peak <= '0;
            end

            if (r_state == obd_pkg::S_TP_WAIT && div_done) begin
                r_tempo <= div_quot[7:0];
            end else if (r_state == obd_pkg::S_TP_GO && r_top_lag == '0) begin
                r_tempo <= '0;
            end

            if (r_state == obd_pkg::S_FLIP) begin
                if (flip_req) begin
                    r_flip_start <= flip_base;
                    if (r_now - flip_base >= 32'(r_listening ? cfg.quiet_time
                                                             : cfg.sustain_time)) begin
                        r_listening   <= !r_listening;
                        r_flip_timing <= 1'b0;
                    end else begin
                        r_flip_timing <= 1'b1;
                    end
                end else begin
                    r_flip_timing <= 1'b0;
                end
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_level  <= i_in_data.sample_level;
            r_now    <= i_in_data.time_ms;
            r_closed <= 1'b0;
        end

        if (r_state == obd_pkg::S_N_WAIT && div_done) r_n <= div_quot;

        if (r_state == obd_pkg::S_NSET) begin
            r_m         <= (r_n > 32'(WINDOW_LEN)) ? FILL_W'(WINDOW_LEN) : FILL_W'(r_n);
            r_k         <= '0;
            r_closed    <= 1'b1;
            r_ci        <= '0;
            r_onset_sum <= '0;
            r_e0        <= '0;
        end

        if (r_state == obd_pkg::S_SHIFT) r_k <= r_k + 1'b1;

        if (r_state == obd_pkg::S_ONSET) begin
            if (r_ci < (AW+1)'(WINDOW_LEN)) begin
                r_ci     <= r_ci + 1'b1;
                r_rd_idx <= r_ci[AW-1:0];
            end
            if (r_rd_vld) begin
                r_prev      <= r_env_q;
                r_onset_sum <= r_onset_sum + SUM_W'(onset_val);
                if (r_rd_idx >= AW'(LAG_HIGH)) begin
                    r_e0 <= r_e0 + ACC_W'(onset_sq);
                end
            end
            if (onset_last) begin
                r_lag     <= LAG_W'(LAG_LOW);
                r_ii      <= AW'(LAG_HIGH);
                r_acc     <= '0;
                r_best    <= '0;
                r_top_lag <= '0;
            end
        end

        if (r_state == obd_pkg::S_CORR) begin
            if (r_issue) begin
                r_cl    <= last_i;
                r_cdone <= last_i && (r_lag == LAG_W'(LAG_HIGH));
                r_clag  <= r_lag;
                if (last_i) begin
                    r_ii  <= AW'(LAG_HIGH);
                    r_lag <= r_lag + 1'b1;
                end else begin
                    r_ii  <= r_ii + 1'b1;
                end
            end
            if (r_cv) begin
                if (r_cl) begin
                    r_acc <= '0;
                    if (corr_sum > r_best) begin
                        r_best    <= corr_sum;
                        r_top_lag <= r_clag;
                    end
                end else begin
                    r_acc <= corr_sum;
                end
            end
        end

        if (out_load) begin
            r_out.is_listening <= r_listening;
            r_out.beat_score   <= (r_peak > obd_pkg::SCORE_MAX) ? obd_pkg::SCORE_MAX_7
                                                                : r_peak[6:0];
            r_out.tempo_bpm    <= r_tempo;
            r_out.frame_closed <= r_closed;
        end
    end

`ifndef SYNTHESIS
    // The divider is started only from a launch state, so it is never restarted while iterating.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (r_state == obd_pkg::S_N_GO || r_state == obd_pkg::S_PK_GO
                           || r_state == obd_pkg::S_TP_GO))
        else $error("divider started outside a launch state");

    // The window never claims more frames than it holds.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW_LEN))
        else $error("window fill exceeds window length");

    // An accepted sample always starts the frame count.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == obd_pkg::S_N_GO))
        else $error("accepted sample did not start processing");

    // A result is only loaded when the output register is free or draining.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");
`endif

endmodule
